// ----- design/rbc16_pkg.sv -----
package rbc16_pkg;

  localparam int WPB         = 4;
  localparam int MAX_ROUNDS  = 32;
  localparam int STORE_DEPTH = WPB * MAX_ROUNDS + 2;
  localparam int KIDX_W      = $clog2(STORE_DEPTH);
  localparam int WORD_W      = 16;
  localparam int BLK_W       = 64;
  localparam int ROUNDS_W    = 6;
  localparam int KEYIDX_W    = 8;
  localparam int OP_W        = 2;
  localparam int SH_W        = 4;
  // Slot of the word that the leading whitening add touches.
  localparam int W2_SLOT     = 2 % WPB;

  localparam logic [ROUNDS_W-1:0] ROUNDS_RST = ROUNDS_W'(20);

  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_ENC  = 2'd1;
  localparam logic [OP_W-1:0] OP_DEC  = 2'd2;

  function automatic logic [WORD_W-1:0] rotl16(input logic [WORD_W-1:0] v,
                                               input logic [SH_W-1:0]   sh);
    logic [2*WORD_W-1:0] d;
    d = {v, v} << sh;
    return d[2*WORD_W-1:WORD_W];
  endfunction

  function automatic logic [WORD_W-1:0] rotr16(input logic [WORD_W-1:0] v,
                                               input logic [SH_W-1:0]   sh);
    logic [2*WORD_W-1:0] d;
    d = {v, v} >> sh;
    return d[WORD_W-1:0];
  endfunction

endpackage

// ----- design/rbc16_ram.sv -----
module rbc16_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 130
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/rotation_block_cipher16.sv -----
// Data-dependent rotation block cipher on four 16-bit words. A load beat
// (op 0) writes one subkey into the store. An encrypt or decrypt beat
// takes the block and then occupies the round unit, one subkey per cycle
// out of the subkey store until the last, which is held while the output
// is blocked: the leading whitening add, one xor/rotate/add step per
// subkey, and the trailing whitening add (decryption undoes them in
// reverse order with subtracts and right rotates). The reset value is 20
// rounds; the input is stalled while the round unit runs. Results wait in
// an output register, so a new beat can be taken while the previous result
// is still held. A rounds value above 32 acts as 32, and the rounds
// register may be written whenever cfg_ready is high.
module rotation_block_cipher16 (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [rbc16_pkg::OP_W-1:0]           in_op,
  input  logic [rbc16_pkg::KEYIDX_W-1:0]       in_key_index,
  input  logic [rbc16_pkg::WORD_W-1:0]         in_key_word,
  input  logic [rbc16_pkg::BLK_W-1:0]          in_block_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [rbc16_pkg::BLK_W-1:0]          out_block_out,
  output logic                                 out_was_decrypt,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rbc16_pkg::ROUNDS_W-1:0]       cfg_rounds
);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;
  typedef logic [rbc16_pkg::WORD_W-1:0] word_t;
  typedef logic [rbc16_pkg::KIDX_W-1:0] kidx_t;

  state_t                            state_r, state_nxt;
  logic [rbc16_pkg::ROUNDS_W-1:0]    rounds_r, rounds_nxt;
  kidx_t                             pos_r, pos_nxt;
  kidx_t                             last_r, last_nxt;
  logic                              dec_r, dec_nxt;
  word_t                             slot_r [rbc16_pkg::WPB];
  word_t                             slot_nxt [rbc16_pkg::WPB];
  logic                              out_valid_r, out_valid_nxt;
  logic [rbc16_pkg::BLK_W-1:0]       out_block_r, out_block_nxt;
  logic                              out_dec_r, out_dec_nxt;

  logic   in_acc;
  logic   is_blk_op;
  kidx_t  rnd_sat;
  kidx_t  last_calc;
  logic   last_step;
  logic   out_free;
  logic   ram_we;
  kidx_t  ram_waddr;
  kidx_t  ram_raddr;
  word_t  subkey;
  word_t  upd [rbc16_pkg::WPB];
  word_t  s0;
  word_t  s1;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign is_blk_op = (in_op == rbc16_pkg::OP_ENC) || (in_op == rbc16_pkg::OP_DEC);

  assign rnd_sat   = (int'(rounds_r) > rbc16_pkg::MAX_ROUNDS) ?
                     rbc16_pkg::KIDX_W'(rbc16_pkg::MAX_ROUNDS) :
                     rbc16_pkg::KIDX_W'(rounds_r);
  assign last_calc = rbc16_pkg::KIDX_W'(rbc16_pkg::WPB) * rnd_sat + kidx_t'(1);

  assign last_step = dec_r ? (pos_r == '0) : (pos_r == last_r);
  assign out_free  = !out_valid_r || !out_stall;

  assign ram_we    = in_acc && (in_op == rbc16_pkg::OP_LOAD) &&
                     (int'(in_key_index) < rbc16_pkg::STORE_DEPTH);
  assign ram_waddr = rbc16_pkg::KIDX_W'(in_key_index);

  // The read address runs one position ahead of the position being worked
  // on, so the registered subkey lines up with it. On the final position it
  // holds, which keeps the subkey valid while the output is blocked.
  always_comb begin
    if (state_r == ST_IDLE) begin
      ram_raddr = (in_op == rbc16_pkg::OP_DEC) ? last_calc : '0;
    end else if (last_step) begin
      ram_raddr = pos_r;
    end else if (dec_r) begin
      ram_raddr = pos_r - kidx_t'(1);
    end else begin
      ram_raddr = pos_r + kidx_t'(1);
    end
  end

  rbc16_ram #(
    .WIDTH (rbc16_pkg::WORD_W),
    .DEPTH (rbc16_pkg::STORE_DEPTH)
  ) u_subkeys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_key_word),
    .raddr (ram_raddr),
    .rdata (subkey)
  );

  // Words are kept rotated so that, but for the leading whitening add, the
  // word being updated is in slot 0 and its right neighbor in slot 1.
  assign s0 = slot_r[0];
  assign s1 = slot_r[1];

  always_comb begin
    for (int k = 0; k < rbc16_pkg::WPB; k++) begin
      upd[k] = slot_r[k];
    end
    if (pos_r == '0) begin
      upd[rbc16_pkg::W2_SLOT] = dec_r ? slot_r[rbc16_pkg::W2_SLOT] - subkey :
                                        slot_r[rbc16_pkg::W2_SLOT] + subkey;
    end else if (pos_r == last_r) begin
      upd[0] = dec_r ? s0 - subkey : s0 + subkey;
    end else if (dec_r) begin
      upd[0] = rbc16_pkg::rotr16(s0 - subkey, s1[rbc16_pkg::SH_W-1:0]) ^ s1;
    end else begin
      upd[0] = rbc16_pkg::rotl16(s0 ^ s1, s1[rbc16_pkg::SH_W-1:0]) + subkey;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    rounds_nxt    = rounds_r;
    pos_nxt       = pos_r;
    last_nxt      = last_r;
    dec_nxt       = dec_r;
    out_valid_nxt = out_valid_r;
    out_block_nxt = out_block_r;
    out_dec_nxt   = out_dec_r;
    for (int k = 0; k < rbc16_pkg::WPB; k++) begin
      slot_nxt[k] = slot_r[k];
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_valid && cfg_ready) begin
      rounds_nxt = cfg_rounds;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && is_blk_op) begin
          state_nxt = ST_RUN;
          last_nxt  = last_calc;
          dec_nxt   = (in_op == rbc16_pkg::OP_DEC);
          pos_nxt   = (in_op == rbc16_pkg::OP_DEC) ? last_calc : '0;
          // Decryption starts at word 1, encryption at word 0.
          for (int k = 0; k < rbc16_pkg::WPB; k++) begin
            if (in_op == rbc16_pkg::OP_DEC) begin
              slot_nxt[k] = in_block_in[(rbc16_pkg::WPB - 1 -
                ((k == rbc16_pkg::WPB - 1) ? 0 : k + 1)) * rbc16_pkg::WORD_W +:
                rbc16_pkg::WORD_W];
            end else begin
              slot_nxt[k] = in_block_in[(rbc16_pkg::WPB - 1 - k) * rbc16_pkg::WORD_W +:
                rbc16_pkg::WORD_W];
            end
          end
        end
      end
      ST_RUN: begin
        if (!last_step) begin
          pos_nxt = dec_r ? pos_r - kidx_t'(1) : pos_r + kidx_t'(1);
          for (int k = 0; k < rbc16_pkg::WPB; k++) begin
            if (dec_r) begin
              slot_nxt[k] = upd[(k == 0) ? rbc16_pkg::WPB - 1 : k - 1];
            end else begin
              slot_nxt[k] = upd[(k == rbc16_pkg::WPB - 1) ? 0 : k + 1];
            end
          end
        end else if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_dec_nxt   = dec_r;
          out_block_nxt = '0;
          // After encryption slot k holds word k+1; after decryption word k.
          for (int j = 0; j < rbc16_pkg::WPB; j++) begin
            out_block_nxt[(rbc16_pkg::WPB - 1 - j) * rbc16_pkg::WORD_W +:
                          rbc16_pkg::WORD_W] =
              dec_r ? upd[j] : upd[(j == 0) ? rbc16_pkg::WPB - 1 : j - 1];
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rounds_r    <= rbc16_pkg::ROUNDS_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rounds_r    <= rounds_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r       <= pos_nxt;
    last_r      <= last_nxt;
    dec_r       <= dec_nxt;
    out_block_r <= out_block_nxt;
    out_dec_r   <= out_dec_nxt;
    for (int k = 0; k < rbc16_pkg::WPB; k++) begin
      slot_r[k] <= slot_nxt[k];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_block_out   = out_block_r;
  assign out_was_decrypt = out_dec_r;

  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RUN))
    else $error("result appeared without a block in the round unit");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (pos_r <= last_r))
    else $error("subkey position left the schedule");

  a_block_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_blk_op) |=> (state_r == ST_RUN))
    else $error("accepted block did not start the round unit");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && last_step && out_valid_r && out_stall) |=>
      (state_r == ST_RUN && $stable(pos_r)))
    else $error("finished block overran a pending result");

endmodule
